// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/b64se_pkg.sv =====
// ----------------------------------------------------------------------------
// b64se_pkg
// Types, constants and the alphabet lookup of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64se_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [7:0]  PAD_CHAR    = 8'd61;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_of_text;
	} char_item_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	// One accepted byte: first symbol, optional second symbol, pad count.
	typedef struct packed {
		logic [5:0] sym0;
		logic [5:0] sym1;
		logic       two;
		logic [1:0] npad;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic over;
	} queue_stat_t;

	typedef struct packed {
		logic       mid_cmd;
		logic [1:0] char_idx;
	} back_stat_t;

	function automatic logic [7:0] sym_ascii(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return w + 8'd65;
		else if (v < 6'd52)
			return w + 8'd71;
		else if (v < 6'd62)
			return w - 8'd4;
		else if (v == 6'd62)
			return 8'd43;
		else
			return 8'd47;
	endfunction

endpackage

// ===== sv/b64se_front.sv =====
// ----------------------------------------------------------------------------
// b64se_front
// Accepts raw bytes, tracks the group phase and leftover bits, and issues
// one symbol command per byte.
// ----------------------------------------------------------------------------
module b64se_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_ready,
	input  b64se_pkg::byte_item_t   byte_item,
	input  b64se_pkg::queue_stat_t  q_stat,
	output logic                    push,
	output b64se_pkg::cmd_t         cmd
);
	import b64se_pkg::*;

	phase_t     phase_q, phase_nxt;
	logic [3:0] carry_q, carry_nxt;
	logic [7:0] b;
	logic       last;

	assign b          = byte_item.data_byte;
	assign last       = byte_item.is_last;
	assign byte_ready = !q_stat.full;
	assign push       = byte_valid && byte_ready;

	always_comb begin
		cmd.last = last;
		unique case (phase_q)
			PH_SECOND: begin
				cmd.sym0  = {carry_q[1:0], b[7:4]};
				cmd.sym1  = {b[3:0], 2'b00};
				cmd.two   = last;
				cmd.npad  = last ? 2'd1 : 2'd0;
				carry_nxt = b[3:0];
				phase_nxt = PH_THIRD;
			end
			PH_THIRD: begin
				cmd.sym0  = {carry_q, b[7:6]};
				cmd.sym1  = b[5:0];
				cmd.two   = 1'b1;
				cmd.npad  = 2'd0;
				carry_nxt = 4'd0;
				phase_nxt = PH_FIRST;
			end
			default: begin
				cmd.sym0  = b[7:2];
				cmd.sym1  = {b[1:0], 4'b0000};
				cmd.two   = last;
				cmd.npad  = last ? 2'd2 : 2'd0;
				carry_nxt = {2'b00, b[1:0]};
				phase_nxt = PH_SECOND;
			end
		endcase
		if (last) begin
			carry_nxt = 4'd0;
			phase_nxt = PH_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= 4'd0;
		end else if (push) begin
			phase_q <= phase_nxt;
			carry_q <= carry_nxt;
		end
	end

endmodule

// ===== sv/b64se_queue.sv =====
// ----------------------------------------------------------------------------
// b64se_queue
// Short register queue of symbol commands between front and back.
// ----------------------------------------------------------------------------
module b64se_queue #(
	parameter int unsigned DEPTH = b64se_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b64se_pkg::cmd_t         push_cmd,
	input  logic                    pop,
	output logic                    head_valid,
	output b64se_pkg::cmd_t         head_cmd,
	output b64se_pkg::queue_stat_t  q_stat
);
	import b64se_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);
	assign q_stat.over  = (count_q > FULL_CNT);
	assign head_valid   = !q_stat.empty;
	assign head_cmd     = mem_q[rd_ptr_q];
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/b64se_back.sv =====
// ----------------------------------------------------------------------------
// b64se_back
// Expands each symbol command into base64 characters, one per cycle while the
// receiver is ready, into the output register.
// ----------------------------------------------------------------------------
module b64se_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  b64se_pkg::cmd_t         head_cmd,
	output logic                    pop,
	output logic                    char_valid,
	input  logic                    char_ready,
	output b64se_pkg::char_item_t   char_item,
	output b64se_pkg::back_stat_t   b_stat
);
	import b64se_pkg::*;

	logic [1:0] idx_q, last_idx;
	logic       out_valid_q, load, at_end;
	char_item_t item_q, item_nxt;

	assign last_idx = {1'b0, head_cmd.two} + head_cmd.npad;
	assign at_end   = (idx_q == last_idx);
	assign load     = head_valid && (!out_valid_q || char_ready);
	assign pop      = load && at_end;

	always_comb begin
		if (idx_q == 2'd0)
			item_nxt.out_char = sym_ascii(head_cmd.sym0);
		else if (idx_q == 2'd1 && head_cmd.two)
			item_nxt.out_char = sym_ascii(head_cmd.sym1);
		else
			item_nxt.out_char = PAD_CHAR;
		item_nxt.end_of_text = head_cmd.last && at_end;
	end

	always_ff @(posedge clk) begin
		if (load)
			item_q <= item_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
		end else if (char_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign char_valid     = out_valid_q;
	assign char_item      = item_q;
	assign b_stat.mid_cmd = (idx_q != 2'd0);
	assign b_stat.char_idx = idx_q;

endmodule

// ===== sv/base64_stream_encoder_top.sv =====
// An accepted byte goes to the command queue, then its characters to the output register.
// Throughput: one byte per cycle while the command queue has room; one
// character per cycle out while the receiver is ready; three bytes give four characters.
// The output character register sets the drain rate.
// Reset: arst_n clears phase, leftover bits, queue pointers and output valid.
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Padded base64 encoder on a byte stream with front, queue and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_stream_encoder_top #(
	parameter int unsigned QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  b64se_pkg::byte_item_t  byte_item,
	output logic                   char_valid,
	input  logic                   char_ready,
	output b64se_pkg::char_item_t  char_item
);
	import b64se_pkg::*;

	logic        push, pop, head_valid;
	cmd_t        push_cmd, head_cmd;
	queue_stat_t q_stat;
	back_stat_t  b_stat;

	b64se_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.q_stat     (q_stat),
		.push       (push),
		.cmd        (push_cmd)
	);

	b64se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.q_stat     (q_stat)
	);

	b64se_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.b_stat     (b_stat)
	);

	`ASSERT_IMPLIES(a_queue_bound, clk, arst_n, 1'b1, !q_stat.over)
	`ASSERT_IMPLIES(a_empty_idle, clk, arst_n, q_stat.empty, !b_stat.mid_cmd)
	`ASSERT_NEXT(a_pad_follows, clk, arst_n, char_valid && char_ready && (char_item.out_char == PAD_CHAR) && !char_item.end_of_text, char_valid && (char_item.out_char == PAD_CHAR))

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams byte messages into the padded base64 encoder under changing
// sender gaps and receiver stalls, and checks every character and its
// end-of-text flag against a bit-level prediction kept in a small class.
// ----------------------------------------------------------------------------
module tb;
	import b64se_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASE_BYTES    = 92;

	class b64_char_model;
		string      alphabet;
		phase_t     grp_phase;
		logic [3:0] carry;
		char_item_t pending_chars[$];
		int         n_errors;
		int         n_bytes;
		int         n_chars;

		function new();
			alphabet  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
			grp_phase = PH_FIRST;
			carry     = '0;
			n_errors  = 0;
			n_bytes   = 0;
			n_chars   = 0;
		endfunction

		function logic [7:0] to_ascii(logic [5:0] v);
			return alphabet[int'(v)];
		endfunction

		function void note_byte(byte_item_t it);
			char_item_t chars[4];
			int         n;
			logic [7:0] b;
			b = it.data_byte;
			n = 0;
			foreach (chars[i]) chars[i] = '0;
			case (grp_phase)
				PH_SECOND: begin
					chars[n++].out_char = to_ascii({carry[1:0], b[7:4]});
					carry = b[3:0];
					grp_phase = PH_THIRD;
					if (it.is_last) begin
						chars[n++].out_char = to_ascii({b[3:0], 2'b00});
						chars[n++].out_char = PAD_CHAR;
					end
				end
				PH_THIRD: begin
					chars[n++].out_char = to_ascii({carry, b[7:6]});
					chars[n++].out_char = to_ascii(b[5:0]);
					carry = '0;
					grp_phase = PH_FIRST;
				end
				default: begin
					chars[n++].out_char = to_ascii(b[7:2]);
					carry = {2'b00, b[1:0]};
					grp_phase = PH_SECOND;
					if (it.is_last) begin
						chars[n++].out_char = to_ascii({b[1:0], 4'b0000});
						chars[n++].out_char = PAD_CHAR;
						chars[n++].out_char = PAD_CHAR;
					end
				end
			endcase
			if (it.is_last) begin
				chars[n - 1].end_of_text = 1'b1;
				grp_phase = PH_FIRST;
				carry = '0;
			end
			for (int i = 0; i < n; i++)
				pending_chars.push_back(chars[i]);
			n_bytes++;
		endfunction

		function void check_char(char_item_t got);
			char_item_t want;
			n_chars++;
			if (pending_chars.size() == 0) begin
				$error("unexpected char: out_char %0d end_of_text %0d",
					got.out_char, got.end_of_text);
				n_errors++;
				return;
			end
			want = pending_chars.pop_front();
			if (got.out_char !== want.out_char) begin
				$error("out_char: expected %0d, got %0d", want.out_char, got.out_char);
				n_errors++;
			end
			if (got.end_of_text !== want.end_of_text) begin
				$error("end_of_text: expected %0d, got %0d",
					want.end_of_text, got.end_of_text);
				n_errors++;
			end
		endfunction
	endclass

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	byte_item_t byte_item  = '0;
	logic       char_valid;
	logic       char_ready = 1'b0;
	char_item_t char_item;

	b64_char_model model = new();

	logic       byte_took = 1'b0;
	logic       char_took = 1'b0;
	int         quiet_cycles = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         n_msgs = 0;
	logic [7:0] msg_buf[$];

	base64_stream_encoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		byte_took = arst_n && byte_valid && byte_ready;
		char_took = arst_n && char_valid && char_ready;
		if (byte_took)
			model.note_byte(byte_item);
		if (char_took)
			model.check_char(char_item);
		if (byte_took || char_took)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			char_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] data, input logic last);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			byte_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_item.data_byte = data;
		byte_item.is_last   = last;
		byte_valid          = 1'b1;
		do @(negedge clk); while (!byte_took);
	endtask

	task automatic send_message();
		foreach (msg_buf[i])
			send_byte(msg_buf[i], i == msg_buf.size() - 1);
		msg_buf.delete();
		n_msgs++;
	endtask

	task automatic random_phase(input int idle_pct, input int stall_pct);
		int start;
		int len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = model.n_bytes;
		while (model.n_bytes - start < PHASE_BYTES) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
			repeat (len) begin
				case ($urandom_range(15))
					0:       msg_buf.push_back(8'h00);
					1:       msg_buf.push_back(8'hFF);
					default: msg_buf.push_back(8'($urandom));
				endcase
			end
			send_message();
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		msg_buf = '{8'h00};                             send_message();
		msg_buf = '{8'hFF};                             send_message();
		msg_buf = '{8'h00, 8'hFF};                      send_message();
		msg_buf = '{8'hFF, 8'hFF};                      send_message();
		msg_buf = '{8'h4D, 8'h61, 8'h6E};               send_message();
		msg_buf = '{8'hFB, 8'hEF, 8'hBE};               send_message();
		msg_buf = '{8'hFF, 8'hFF, 8'hFF};               send_message();
		msg_buf = '{8'h00, 8'h00, 8'h00, 8'h00};        send_message();
		msg_buf = '{8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55}; send_message();

		random_phase(0, 0);
		random_phase(73, 0);
		random_phase(0, 73);
		random_phase(33, 33);

		byte_valid = 1'b0;
		while (model.pending_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("tb: %0d bytes in %0d messages encoded, %0d characters checked",
			model.n_bytes, n_msgs, model.n_chars);
		$display("tb: idle mixes covered: none, sender gaps, receiver stalls, both");
		if (model.n_errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
